// ===== rtl/core/cfp_pkg.sv =====
// cfp_pkg: shared types, codes and constants of the checksummed frame parser
// used by cfp_cfg_regs, cfp_frame_tracker and checksummed_frame_parser_core
// no dependencies
package cfp_pkg;

  // accepted frame lengths
  localparam logic [7:0] INFO_LEN = 8'd13;
  localparam logic [7:0] ACK_LEN  = 8'd7;

  // configuration register indexes
  localparam int CFG_IDX_W = 3;
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NODE_ADDR_HIGH = 3'd0,
    REG_NODE_ADDR_LOW  = 3'd1,
    REG_NODE_CHANNEL   = 3'd2,
    REG_TYPE_CONTROL   = 3'd3,
    REG_TYPE_REPORT    = 3'd4,
    REG_TYPE_NEXT_ACK  = 3'd5,
    REG_TYPE_PREV_ACK  = 3'd6
  } cfg_reg_t;

  localparam int CFG_DATA_W = 8;

  // register reset values
  localparam logic [7:0] RST_NODE_ADDR_HIGH = 8'd0;
  localparam logic [7:0] RST_NODE_ADDR_LOW  = 8'd0;
  localparam logic [7:0] RST_NODE_CHANNEL   = 8'd0;
  localparam logic [7:0] RST_TYPE_CONTROL   = 8'd0;
  localparam logic [7:0] RST_TYPE_REPORT    = 8'd1;
  localparam logic [7:0] RST_TYPE_NEXT_ACK  = 8'd2;
  localparam logic [7:0] RST_TYPE_PREV_ACK  = 8'd3;

  typedef struct packed {
    logic [7:0] node_addr_high;
    logic [7:0] node_addr_low;
    logic [7:0] node_channel;
    logic [7:0] type_control;
    logic [7:0] type_report;
    logic [7:0] type_next_ack;
    logic [7:0] type_prev_ack;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_LEN_ERR  = 2'd1,
    ST_SUM_ERR  = 2'd2,
    ST_ADDR_ERR = 2'd3
  } status_t;

  // result item, first field in the highest bits
  typedef struct packed {
    logic [15:0] frame_checksum;
    logic [31:0] valve_state;
    logic [7:0]  aux_byte;
    logic [7:0]  routing;
    logic [7:0]  frame_length;
    logic [7:0]  frame_type;
    status_t     status;
  } result_t;

  localparam int RESULT_W   = $bits(result_t);
  localparam int OUT_DATA_W = ((RESULT_W + 7) / 8) * 8;

endpackage

// ===== rtl/core/checksummed_frame_parser_core.sv =====
// checksummed_frame_parser_core: top level of the byte-serial frame parser
// depends on cfp_pkg, cfp_cfg_regs and cfp_frame_tracker
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+------------------------------------
//  in_      | slave     | in_tvalid / in_tready | in_tdata: rx_byte, in_tuser: start
//  out_     | master    | out_tvalid/out_tready | out_tdata: one verdict per frame
//  cfg_     | write     | cfg_we                | cfg_index, cfg_wdata
//
// one item per cycle while the output is not stalled: an item is held in the
// input register, then the frame tracker updates its state and, on the last
// byte or a bad length byte, loads the output register, which offers the verdict
// synchronous active-low reset closes any open frame and restores the registers
// a stalled output holds its verdict; the input register keeps taking items as
// long as the output register is free or being drained the same cycle
module checksummed_frame_parser_core (
  input  logic                            clk,
  input  logic                            rst_n,
  // input items
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] rx_byte
  input  logic [0:0]                      in_tuser,   // [0] frame_start
  // result items
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [9:2] frame_type, [17:10] frame_length, [25:18] routing,
  // [33:26] aux_byte, [65:34] valve_state, [81:66] frame_checksum, rest zero
  output logic [cfp_pkg::OUT_DATA_W-1:0]  out_tdata,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [cfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfp_pkg::CFG_DATA_W-1:0]  cfg_wdata
);
  import cfp_pkg::*;

  cfg_t    cfg;
  result_t res;
  logic    res_valid;

  // input register
  logic       in_valid_r;
  logic [7:0] in_byte_r;
  logic       in_start_r;

  // output register
  logic       out_valid_r;
  result_t    out_data_r;

  logic advance;

  // the held item moves on whenever the output register can take a verdict
  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  cfp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  cfp_frame_tracker u_tracker (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (advance),
    .rx_byte     (in_byte_r),
    .frame_start (in_start_r),
    .cfg         (cfg),
    .res_valid   (res_valid),
    .res         (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) in_valid_r <= in_tvalid;
      // drain first, a fresh verdict overrides
      if (out_tready) out_valid_r <= 1'b0;
      if (advance && res_valid) out_valid_r <= 1'b1;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_byte_r  <= in_tdata;
      in_start_r <= in_tuser[0];
    end
    if (advance && res_valid) out_data_r <= res;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W - RESULT_W){1'b0}}, out_data_r};

endmodule

// ===== rtl/core/cfp_cfg_regs.sv =====
// cfp_cfg_regs: node address and type code registers behind the write port
// depends on cfp_pkg
module cfp_cfg_regs (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [cfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output cfp_pkg::cfg_t                   cfg
);
  import cfp_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.node_addr_high <= RST_NODE_ADDR_HIGH;
      cfg_r.node_addr_low  <= RST_NODE_ADDR_LOW;
      cfg_r.node_channel   <= RST_NODE_CHANNEL;
      cfg_r.type_control   <= RST_TYPE_CONTROL;
      cfg_r.type_report    <= RST_TYPE_REPORT;
      cfg_r.type_next_ack  <= RST_TYPE_NEXT_ACK;
      cfg_r.type_prev_ack  <= RST_TYPE_PREV_ACK;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_NODE_ADDR_HIGH: cfg_r.node_addr_high <= cfg_wdata;
        REG_NODE_ADDR_LOW:  cfg_r.node_addr_low  <= cfg_wdata;
        REG_NODE_CHANNEL:   cfg_r.node_channel   <= cfg_wdata;
        REG_TYPE_CONTROL:   cfg_r.type_control   <= cfg_wdata;
        REG_TYPE_REPORT:    cfg_r.type_report    <= cfg_wdata;
        REG_TYPE_NEXT_ACK:  cfg_r.type_next_ack  <= cfg_wdata;
        REG_TYPE_PREV_ACK:  cfg_r.type_prev_ack  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/core/cfp_frame_tracker.sv =====
// cfp_frame_tracker: per-frame state, running sum, field capture and verdict
// depends on cfp_pkg
module cfp_frame_tracker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       rx_byte,
  input  logic             frame_start,
  input  cfp_pkg::cfg_t    cfg,
  output logic             res_valid,
  output cfp_pkg::result_t res
);
  import cfp_pkg::*;

  logic        active_r, active_nxt;
  logic [3:0]  byte_index_r, byte_index_nxt;
  logic [7:0]  length_r, length_nxt;
  logic [15:0] sum_r, sum_nxt;
  logic [7:0]  type_r, type_nxt;
  logic        mismatch_r, mismatch_nxt;
  logic [7:0]  routing_r, routing_nxt;
  logic [7:0]  aux_r, aux_nxt;
  logic [31:0] valve_r, valve_nxt;
  logic [15:0] trailer_r, trailer_nxt;
  logic [15:0] tail_r, tail_nxt;

  logic [8:0] idx9;
  logic [8:0] len9;
  logic       len_ok;
  logic       is_info;
  logic       is_ack;

  assign idx9   = {5'd0, byte_index_r};
  assign len9   = {1'b0, length_r};
  assign len_ok = (rx_byte == INFO_LEN) || (rx_byte == ACK_LEN);

  always_comb begin
    active_nxt     = active_r;
    byte_index_nxt = byte_index_r;
    length_nxt     = length_r;
    sum_nxt        = sum_r;
    type_nxt       = type_r;
    mismatch_nxt   = mismatch_r;
    routing_nxt    = routing_r;
    aux_nxt        = aux_r;
    valve_nxt      = valve_r;
    trailer_nxt    = trailer_r;
    tail_nxt       = tail_r;
    res_valid      = 1'b0;
    res            = '0;
    is_info        = 1'b0;
    is_ack         = 1'b0;

    if (step && frame_start) begin
      length_nxt     = rx_byte;
      byte_index_nxt = 4'd1;
      sum_nxt        = '0;
      type_nxt       = '0;
      mismatch_nxt   = 1'b0;
      routing_nxt    = '0;
      aux_nxt        = '0;
      valve_nxt      = '0;
      trailer_nxt    = '0;
      tail_nxt       = '0;
      active_nxt     = len_ok;
      if (!len_ok) begin
        res_valid        = 1'b1;
        res.status       = ST_LEN_ERR;
        res.frame_length = rx_byte;
      end
    end else if (step && active_r) begin
      // body bytes feed the sum, the last two form the trailer
      if ((idx9 + 9'd2) < len9) sum_nxt = sum_r + {8'd0, rx_byte};
      if (byte_index_r == 4'd1) type_nxt = rx_byte;
      if (byte_index_r == 4'd2 && rx_byte != cfg.node_addr_high) mismatch_nxt = 1'b1;
      if (byte_index_r == 4'd3 && rx_byte != cfg.node_addr_low)  mismatch_nxt = 1'b1;
      if (byte_index_r == 4'd4 && rx_byte != cfg.node_channel)   mismatch_nxt = 1'b1;
      if (byte_index_r == 4'd5) routing_nxt = rx_byte;
      if (byte_index_r == 4'd6) aux_nxt = rx_byte;
      if (byte_index_r >= 4'd7 && byte_index_r <= 4'd10) valve_nxt = {valve_r[23:0], rx_byte};
      if (byte_index_r == 4'd11 || byte_index_r == 4'd12) trailer_nxt = {trailer_r[7:0], rx_byte};
      if ((idx9 + 9'd2) >= len9) tail_nxt = {tail_r[7:0], rx_byte};

      if ((idx9 + 9'd1) < len9) begin
        byte_index_nxt = byte_index_r + 4'd1;
      end else begin
        // last byte: deliver the verdict
        active_nxt       = 1'b0;
        byte_index_nxt   = 4'd0;
        res_valid        = 1'b1;
        res.frame_length = length_r;
        is_info = (type_nxt == cfg.type_control) || (type_nxt == cfg.type_report);
        is_ack  = (type_nxt == cfg.type_next_ack) || (type_nxt == cfg.type_prev_ack);
        if (sum_nxt != tail_nxt) begin
          res.status = ST_SUM_ERR;
        end else if (mismatch_nxt) begin
          res.status = ST_ADDR_ERR;
        end else begin
          res.status     = ST_OK;
          res.frame_type = type_nxt;
          if (is_info) begin
            res.routing        = routing_nxt;
            res.aux_byte       = aux_nxt;
            res.valve_state    = valve_nxt;
            res.frame_checksum = trailer_nxt;
          end else if (is_ack) begin
            res.frame_checksum = {routing_nxt, aux_nxt};
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r     <= 1'b0;
      byte_index_r <= 4'd0;
      length_r     <= 8'd0;
    end else begin
      active_r     <= active_nxt;
      byte_index_r <= byte_index_nxt;
      length_r     <= length_nxt;
    end
  end

  // payload state, always rewritten at frame start before use
  always_ff @(posedge clk) begin
    sum_r      <= sum_nxt;
    type_r     <= type_nxt;
    mismatch_r <= mismatch_nxt;
    routing_r  <= routing_nxt;
    aux_r      <= aux_nxt;
    valve_r    <= valve_nxt;
    trailer_r  <= trailer_nxt;
    tail_r     <= tail_nxt;
  end

  a_active_len : assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (length_r == INFO_LEN || length_r == ACK_LEN))
    else $error("open frame with unsupported length");

  a_index_range : assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (byte_index_r != 4'd0 && {4'd0, byte_index_r} < length_r))
    else $error("byte index outside open frame");

  a_bad_len_closes : assert property (@(posedge clk) disable iff (!rst_n)
    (step && frame_start && !len_ok) |=> !active_r)
    else $error("frame stayed open after length error");

  a_len_err_on_start : assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && res.status == ST_LEN_ERR) |-> (step && frame_start))
    else $error("length error not tied to a length byte");

  a_verdict_closes : assert property (@(posedge clk) disable iff (!rst_n)
    (res_valid && !frame_start) |=> (!active_r && byte_index_r == 4'd0))
    else $error("frame still open after its verdict");

endmodule

// ===== dv/cfp_verdict_checker.sv =====
// cfp_verdict_checker: watches the input, result and configuration ports of the
// frame parser, predicts one verdict per frame and compares field by field
// depends on cfp_pkg
module cfp_verdict_checker (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  input  logic [7:0]                      in_tdata,   // [7:0] rx_byte
  input  logic [0:0]                      in_tuser,   // [0] frame_start
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [1:0] status, [9:2] frame_type, [17:10] frame_length, [25:18] routing,
  // [33:26] aux_byte, [65:34] valve_state, [81:66] frame_checksum, rest zero
  input  logic [cfp_pkg::OUT_DATA_W-1:0]  out_tdata,
  input  logic                            cfg_we,
  input  logic [cfp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cfp_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  output int                              fail_count,
  output int                              pending
);
  timeunit 1ns;
  timeprecision 1ps;
  import cfp_pkg::*;

  localparam int PAD_W = OUT_DATA_W - RESULT_W;

  cfg_t        node_cfg;
  logic        frame_open;
  logic [3:0]  pos;
  logic [7:0]  len_byte;
  logic [15:0] running_sum;
  logic [7:0]  type_byte;
  logic        addr_bad;
  logic [7:0]  routing_byte;
  logic [7:0]  aux_val;
  logic [31:0] valve_word;
  logic [15:0] trailer_word;
  logic [15:0] tail_word;
  result_t     verdict_q[$];
  int          fails = 0;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  task automatic clear_frame();
    pos = 4'd0;
    len_byte = 8'd0;
    running_sum = 16'd0;
    type_byte = 8'd0;
    addr_bad = 1'b0;
    routing_byte = 8'd0;
    aux_val = 8'd0;
    valve_word = 32'd0;
    trailer_word = 16'd0;
    tail_word = 16'd0;
  endtask

  // advance the frame state by one byte; emit is set when a verdict is due
  task automatic parse_byte(input logic [7:0] b, input logic start,
                            output logic emit, output result_t v);
    int p;
    int n;
    v = '0;
    emit = 1'b0;
    if (start) begin
      clear_frame();
      len_byte = b;
      pos = 4'd1;
      if (b != INFO_LEN && b != ACK_LEN) begin
        frame_open = 1'b0;
        v.status = ST_LEN_ERR;
        v.frame_length = b;
        emit = 1'b1;
      end else begin
        frame_open = 1'b1;
      end
    end else if (frame_open) begin
      p = int'(pos);
      n = int'(len_byte);
      if (p + 2 < n) running_sum = running_sum + {8'd0, b};
      case (p)
        1: type_byte = b;
        2: if (b != node_cfg.node_addr_high) addr_bad = 1'b1;
        3: if (b != node_cfg.node_addr_low) addr_bad = 1'b1;
        4: if (b != node_cfg.node_channel) addr_bad = 1'b1;
        5: routing_byte = b;
        6: aux_val = b;
        default: ;
      endcase
      if (p >= 7 && p <= 10) valve_word = {valve_word[23:0], b};
      if (p == 11 || p == 12) trailer_word = {trailer_word[7:0], b};
      if (p + 2 >= n) tail_word = {tail_word[7:0], b};
      if (p + 1 < n) begin
        pos = pos + 4'd1;
      end else begin
        frame_open = 1'b0;
        pos = 4'd0;
        emit = 1'b1;
        v.frame_length = len_byte;
        if (running_sum != tail_word) begin
          v.status = ST_SUM_ERR;
        end else if (addr_bad) begin
          v.status = ST_ADDR_ERR;
        end else begin
          v.status = ST_OK;
          v.frame_type = type_byte;
          if (type_byte == node_cfg.type_control || type_byte == node_cfg.type_report) begin
            v.routing = routing_byte;
            v.aux_byte = aux_val;
            v.valve_state = valve_word;
            v.frame_checksum = trailer_word;
          end else if (type_byte == node_cfg.type_next_ack ||
                       type_byte == node_cfg.type_prev_ack) begin
            v.frame_checksum = {routing_byte, aux_val};
          end
        end
      end
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t mismatch %s expected %h actual %h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : watch
    result_t    want;
    result_t    got;
    result_t    fresh;
    logic       emit;
    logic [PAD_W-1:0] pad;
    if (!rst_n) begin
      node_cfg.node_addr_high = RST_NODE_ADDR_HIGH;
      node_cfg.node_addr_low  = RST_NODE_ADDR_LOW;
      node_cfg.node_channel   = RST_NODE_CHANNEL;
      node_cfg.type_control   = RST_TYPE_CONTROL;
      node_cfg.type_report    = RST_TYPE_REPORT;
      node_cfg.type_next_ack  = RST_TYPE_NEXT_ACK;
      node_cfg.type_prev_ack  = RST_TYPE_PREV_ACK;
      frame_open = 1'b0;
      clear_frame();
      verdict_q.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        got = result_t'(out_tdata[RESULT_W-1:0]);
        pad = out_tdata[OUT_DATA_W-1:RESULT_W];
        if (verdict_q.size() == 0) begin
          fails++;
          $display("%0t unexpected verdict expected none actual %h", $time, out_tdata);
        end else begin
          want = verdict_q.pop_front();
          check_field("status", 32'(want.status), 32'(got.status));
          check_field("frame_type", 32'(want.frame_type), 32'(got.frame_type));
          check_field("frame_length", 32'(want.frame_length), 32'(got.frame_length));
          check_field("routing", 32'(want.routing), 32'(got.routing));
          check_field("aux_byte", 32'(want.aux_byte), 32'(got.aux_byte));
          check_field("valve_state", want.valve_state, got.valve_state);
          check_field("frame_checksum", 32'(want.frame_checksum), 32'(got.frame_checksum));
          check_field("padding", 32'd0, 32'(pad));
        end
      end
      if (in_tvalid && in_tready) begin
        parse_byte(in_tdata, in_tuser[0], emit, fresh);
        if (emit) verdict_q.push_back(fresh);
      end
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          REG_NODE_ADDR_HIGH: node_cfg.node_addr_high = cfg_wdata;
          REG_NODE_ADDR_LOW:  node_cfg.node_addr_low  = cfg_wdata;
          REG_NODE_CHANNEL:   node_cfg.node_channel   = cfg_wdata;
          REG_TYPE_CONTROL:   node_cfg.type_control   = cfg_wdata;
          REG_TYPE_REPORT:    node_cfg.type_report    = cfg_wdata;
          REG_TYPE_NEXT_ACK:  node_cfg.type_next_ack  = cfg_wdata;
          REG_TYPE_PREV_ACK:  node_cfg.type_prev_ack  = cfg_wdata;
          default: ;
        endcase
      end
    end
    pending <= verdict_q.size();
    fail_count <= fails;
  end

endmodule

// ===== dv/checksummed_frame_parser_core_tb.sv =====
// checksummed_frame_parser_core_tb: drives frames, configuration and back-pressure
// into the frame parser and gives the verdict; checking sits in cfp_verdict_checker
// depends on cfp_pkg, cfp_verdict_checker and checksummed_frame_parser_core
module checksummed_frame_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import cfp_pkg::*;

  localparam int FRAME_ITEM_GOAL = 650;
  localparam int PHASES          = 6;

  typedef logic [7:0] frame_bytes_t [0:12];

  logic                    clk = 1'b0;
  logic                    rst_n;
  logic                    in_tvalid;
  logic                    in_tready;
  logic [7:0]              in_tdata;   // [7:0] rx_byte
  logic [0:0]              in_tuser;   // [0] frame_start
  logic                    out_tvalid;
  logic                    out_tready = 1'b0;
  // [1:0] status, [9:2] frame_type, [17:10] frame_length, [25:18] routing,
  // [33:26] aux_byte, [65:34] valve_state, [81:66] frame_checksum, rest zero
  logic [OUT_DATA_W-1:0]   out_tdata;
  logic                    cfg_we;
  logic [CFG_IDX_W-1:0]    cfg_index;
  logic [CFG_DATA_W-1:0]   cfg_wdata;
  int                      fail_count;
  int                      pending;

  // sender pacing and the configuration the frames are built against
  cfg_t         cur_cfg;
  frame_bytes_t fr;
  int           burst_left = 0;
  int           gap_max = 8;
  int           frame_items = 0;

  always #5 clk = ~clk;

  checksummed_frame_parser_core uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  cfp_verdict_checker verdict_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // receiver back-pressure: switches between always ready, coin flips,
  // a regular periodic stall and long stall runs
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_left = $urandom_range(20, 200);
    end
    stall_left--;
    stall_tick++;
    case (stall_mode)
      0: out_tready <= 1'b1;
      1: out_tready <= 1'($urandom_range(0, 1));
      2: out_tready <= (stall_tick % 5) != 0;
      default: out_tready <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // one input item; valid stays high after acceptance so the next item can
  // follow back to back, a gap lowers it once at the start of a new burst
  task automatic send_item(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 30);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, gap_max);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tuser  <= start;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // wrapping 16-bit sum of bytes 1 to len-3 of the frame buffer
  function automatic logic [15:0] byte_sum(input int len);
    logic [15:0] s;
    s = 16'd0;
    for (int k = 1; k <= len - 3; k++) s = s + {8'd0, fr[k]};
    return s;
  endfunction

  // first nbytes of the frame buffer, the length byte flagged as start
  task automatic send_frame(input int nbytes);
    for (int k = 0; k < nbytes; k++) send_item(fr[k], k == 0);
  endtask

  // stop feeding and let every verdict drain, then cover the pipeline latency
  task automatic settle();
    in_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_reg_t idx, input logic [7:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
  endtask

  // every register written, write enable dropped only after the last one
  task automatic apply_config(input cfg_t c);
    put_reg(REG_NODE_ADDR_HIGH, c.node_addr_high);
    put_reg(REG_NODE_ADDR_LOW,  c.node_addr_low);
    put_reg(REG_NODE_CHANNEL,   c.node_channel);
    put_reg(REG_TYPE_CONTROL,   c.type_control);
    put_reg(REG_TYPE_REPORT,    c.type_report);
    put_reg(REG_TYPE_NEXT_ACK,  c.type_next_ack);
    put_reg(REG_TYPE_PREV_ACK,  c.type_prev_ack);
    cfg_we <= 1'b0;
    cur_cfg = c;
  endtask

  // one random frame: mostly well formed against the current configuration,
  // with bad lengths, wrong addresses, bad trailers and cut-off frames mixed in
  task automatic random_frame();
    int          len;
    int          nbytes;
    int          pick;
    int          noise;
    logic [15:0] s;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      // bad length byte, then a few stray bytes that must be ignored
      case ($urandom_range(0, 6))
        0: len = 0;
        1: len = 255;
        2: len = int'(ACK_LEN) - 1;
        3: len = int'(ACK_LEN) + 1;
        4: len = int'(INFO_LEN) - 1;
        5: len = int'(INFO_LEN) + 1;
        default: begin
          len = $urandom_range(0, 255);
          if (len == ACK_LEN || len == INFO_LEN) len = len + 1;
        end
      endcase
      send_item(len[7:0], 1'b1);
      frame_items++;
      noise = $urandom_range(0, 3);
      repeat (noise) send_item(8'($urandom_range(0, 255)), 1'b0);
      return;
    end
    len = (pick < 55) ? int'(INFO_LEN) : int'(ACK_LEN);
    fr[0] = len[7:0];
    // type code: mostly one of the configured codes, sometimes unknown
    case ($urandom_range(0, 5))
      0: fr[1] = cur_cfg.type_control;
      1: fr[1] = cur_cfg.type_report;
      2: fr[1] = cur_cfg.type_next_ack;
      3: fr[1] = cur_cfg.type_prev_ack;
      default: fr[1] = 8'($urandom_range(0, 255));
    endcase
    fr[2] = cur_cfg.node_addr_high;
    fr[3] = cur_cfg.node_addr_low;
    fr[4] = cur_cfg.node_channel;
    if ($urandom_range(0, 99) < 15)
      fr[$urandom_range(2, 4)] ^= 8'($urandom_range(1, 255));
    for (int k = 5; k < 13; k++) fr[k] = 8'($urandom_range(0, 255));
    s = byte_sum(len);
    if ($urandom_range(0, 99) < 15) s ^= 16'($urandom_range(1, 65535));
    fr[len-2] = s[15:8];
    fr[len-1] = s[7:0];
    nbytes = len;
    // cut-off frame: the next start drops it
    if ($urandom_range(0, 99) < 8) nbytes = $urandom_range(1, len - 1);
    send_frame(nbytes);
    frame_items += nbytes;
    // idle noise after a complete frame
    if (nbytes == len && $urandom_range(0, 99) < 5) begin
      noise = $urandom_range(1, 3);
      repeat (noise) send_item(8'($urandom_range(0, 255)), 1'b0);
    end
  endtask

  initial begin
    cfg_t c;
    logic [7:0] v;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = 8'd0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_index = REG_NODE_ADDR_HIGH;
    cfg_wdata = 8'd0;
    cur_cfg.node_addr_high = RST_NODE_ADDR_HIGH;
    cur_cfg.node_addr_low  = RST_NODE_ADDR_LOW;
    cur_cfg.node_channel   = RST_NODE_CHANNEL;
    cur_cfg.type_control   = RST_TYPE_CONTROL;
    cur_cfg.type_report    = RST_TYPE_REPORT;
    cur_cfg.type_next_ack  = RST_TYPE_NEXT_ACK;
    cur_cfg.type_prev_ack  = RST_TYPE_PREV_ACK;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part on the reset configuration
    // length error on the smallest byte, then a stray byte while idle
    send_item(8'h00, 1'b1);
    send_item(8'hA5, 1'b0);
    // length error on the largest byte
    send_item(8'hFF, 1'b1);
    // good ack frame toward the next node
    fr[0] = ACK_LEN;
    fr[1] = RST_TYPE_NEXT_ACK;
    fr[2] = RST_NODE_ADDR_HIGH;
    fr[3] = RST_NODE_ADDR_LOW;
    fr[4] = RST_NODE_CHANNEL;
    {fr[5], fr[6]} = byte_sum(int'(ACK_LEN));
    send_frame(int'(ACK_LEN));
    // control frame with all-ones payload so the sum carries
    fr[0] = INFO_LEN;
    fr[1] = RST_TYPE_CONTROL;
    for (int k = 5; k <= 10; k++) fr[k] = 8'hFF;
    {fr[11], fr[12]} = byte_sum(int'(INFO_LEN));
    send_frame(int'(INFO_LEN));

    // random phases, each on its own configuration
    for (int phase = 0; phase < PHASES; phase++) begin
      // the sender sometimes runs without gaps for a whole phase
      gap_max = (phase % 3 == 1) ? 0 : 8;
      if (phase > 0) begin
        settle();
        c.node_addr_high = 8'($urandom_range(0, 255));
        c.node_addr_low  = 8'($urandom_range(0, 255));
        c.node_channel   = 8'($urandom_range(0, 255));
        case (phase)
          1: begin
            // all ones on the addresses, top codes on the types
            c.node_addr_high = 8'hFF;
            c.node_addr_low  = 8'hFF;
            c.node_channel   = 8'hFF;
            c.type_control   = 8'hFF;
            c.type_report    = 8'hFE;
            c.type_next_ack  = 8'hFD;
            c.type_prev_ack  = 8'hFC;
          end
          2: begin
            // one code for every type: the control and report path must win
            v = 8'($urandom_range(0, 255));
            c.type_control  = v;
            c.type_report   = v;
            c.type_next_ack = v;
            c.type_prev_ack = v;
          end
          3: begin
            // zero addresses, report shares with next ack
            c.node_addr_high = 8'h00;
            c.node_addr_low  = 8'h00;
            c.node_channel   = 8'h00;
            c.type_control   = 8'h00;
            c.type_report    = 8'h80;
            c.type_next_ack  = 8'h80;
            c.type_prev_ack  = 8'h7F;
          end
          default: begin
            // small code range so codes collide now and then
            c.type_control  = 8'($urandom_range(0, 5));
            c.type_report   = 8'($urandom_range(0, 5));
            c.type_next_ack = 8'($urandom_range(0, 5));
            c.type_prev_ack = 8'($urandom_range(0, 5));
          end
        endcase
        apply_config(c);
      end
      while (frame_items < (phase + 1) * FRAME_ITEM_GOAL / PHASES) random_frame();
    end

    settle();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog well above the slowest legal run
  initial begin
    #2000000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
